// File: design/twcp_pkg.sv
// Package: shared types and constants for the textured wall column pixel core
package twcp_pkg;

  localparam int unsigned ScreenHeightDef = 512;
  localparam int unsigned NumTexturesDef  = 4;
  localparam int unsigned MaxTexDimDef    = 64;

  localparam logic [31:0] CeilingReset = 32'h0087_CEEB;
  localparam logic [31:0] FloorReset   = 32'h228B_22BB;

  // register indexes
  localparam logic [1:0] RegTexWidth  = 2'd0;
  localparam logic [1:0] RegTexHeight = 2'd1;
  localparam logic [1:0] RegCeiling   = 2'd2;
  localparam logic [1:0] RegFloor     = 2'd3;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModePixel = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [1:0]  tex_select;
    logic [11:0] texel_addr;
    logic [31:0] texel_word;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [9:0]  span_top;
    logic [10:0] span_bottom;
    logic [15:0] wall_height;
    logic [5:0]  tex_column;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_x;
    logic [9:0]  out_y;
    logic [31:0] out_color;
    logic        out_write;
  } out_item_t;

endpackage

// File: design/textured_wall_column_pixel_core.sv
// Top level: texel store, step divider, row mapping and pixel selection
//
//  channel | signals                    | carries
//  in      | in_valid_i/in_ready_o      | in_item_t (load texel or pixel)
//  out     | out_valid_o/out_ready_i    | out_item_t (one per pixel item)
//  cfg     | cfg_we_i/cfg_idx_i/cfg_data_i | width, height, colours
//
// One item a cycle enters while the output is not stalled; the path runs through the 23-stage
// step divider, the row multiply and modulo stages and the registered store read.
// All stages advance together; an output stall holds the whole pipeline.
// A texel load writes the store when it reaches the store stage, in item order.
// The store has no reset; configuration registers reset to their defaults.
module textured_wall_column_pixel_core #(
  parameter int unsigned ScreenHeight = twcp_pkg::ScreenHeightDef,
  parameter int unsigned NumTextures  = twcp_pkg::NumTexturesDef,
  parameter int unsigned MaxTexDim    = twcp_pkg::MaxTexDimDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  twcp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output twcp_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  localparam int unsigned TexSlot = MaxTexDim * MaxTexDim;
  localparam int unsigned Depth   = NumTextures * TexSlot;
  localparam int unsigned AW      = $clog2(Depth);
  localparam int unsigned Half    = ScreenHeight / 2;

  // configuration registers
  logic [6:0]  tw_q, th_q;
  logic [31:0] ceil_q, floor_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q    <= 7'd64;
      th_q    <= 7'd64;
      ceil_q  <= twcp_pkg::CeilingReset;
      floor_q <= twcp_pkg::FloorReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        twcp_pkg::RegTexWidth:  tw_q    <= cfg_data_i[6:0];
        twcp_pkg::RegTexHeight: th_q    <= cfg_data_i[6:0];
        twcp_pkg::RegCeiling:   ceil_q  <= cfg_data_i;
        twcp_pkg::RegFloor:     floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped texture dimensions
  logic [6:0] h_c, w_c;
  always_comb begin
    h_c = th_q;
    if (th_q < 7'd2) h_c = 7'd2;
    else if (th_q > 7'(MaxTexDim)) h_c = 7'(MaxTexDim);
    w_c = tw_q;
    if (tw_q < 7'd1) w_c = 7'd1;
    else if (tw_q > 7'(MaxTexDim)) w_c = 7'(MaxTexDim);
  end

  // global pipeline enable: the output register is free or is emptied
  logic adv;
  logic out_v_q;
  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;

  // stage 0: decode the item, classify the pixel
  typedef struct packed {
    logic        vld;
    logic        load;
    logic        tex_ok;
    logic [1:0]  tex;
    logic [11:0] taddr;
    logic [31:0] word;
    logic [9:0]  px;
    logic [9:0]  py;
    logic [1:0]  kind;   // 0 colour held, 1 texture, 2 no write
    logic [31:0] color;
    logic [5:0]  col;
    logic [16:0] base;   // y - H/2 + lh/2, signed
  } tag_t;

  localparam logic [1:0] KColor = 2'd0;
  localparam logic [1:0] KTex   = 2'd1;
  localparam logic [1:0] KSkip  = 2'd2;

  twcp_pkg::in_item_t it;
  tag_t t0;
  logic [15:0] lh;
  assign it = in_item_i;
  always_comb begin
    lh = (it.wall_height == 16'd0) ? 16'd1 : it.wall_height;
    t0        = '0;
    t0.vld    = in_valid_i;
    t0.load   = (it.mode == twcp_pkg::ModeLoad);
    t0.tex_ok = (32'(it.tex_select) < NumTextures);
    t0.tex    = it.tex_select;
    t0.taddr  = it.texel_addr;
    t0.word   = it.texel_word;
    t0.px     = it.pixel_x;
    t0.py     = it.pixel_y;
    t0.col    = it.tex_column;
    t0.base   = 17'(it.pixel_y) - 17'(Half) + 17'(lh[15:1]);
    if (32'(it.pixel_y) >= ScreenHeight) t0.kind = KSkip;
    else if ({1'b0, it.pixel_y} >= it.span_bottom) begin
      t0.kind = KColor; t0.color = floor_q;
    end else if (it.pixel_y < it.span_top) begin
      t0.kind = KColor; t0.color = ceil_q;
    end else if (it.pixel_y == it.span_top) t0.kind = KSkip;
    else t0.kind = KTex;
  end

  logic [22:0] step;
  tag_t        t1;
  twcp_step_div #(.Tag($bits(tag_t))) u_div (
    .clk_i, .rst_ni, .en_i(adv),
    .num_i({h_c, 16'd0}), .den_i(lh),
    .tag_i(t0), .quo_o(step), .tag_o(t1)
  );

  // stage A: pos = base * step (signed 17 x 24 bits)
  tag_t t2_q;
  logic signed [40:0] pos_q;
  logic vld2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t2_q  <= t1;
      pos_q <= 41'($signed(t1.base)) * 41'($signed({1'b0, step}));
    end
  end

  // reciprocal table: floor((2^32-1)/k) for the modulus k = h-1
  function automatic logic [31:0] recip_of(logic [6:0] k);
    logic [31:0] r;
    r = 32'hFFFF_FFFF;
    for (int i = 1; i < int'(MaxTexDim); i++) begin
      if (k == 7'(i)) r = 32'(64'hFFFF_FFFF / 64'(i));
    end
    return r;
  endfunction

  // stage B: integer row, modulo by (h-1) via repeated subtraction is too deep;
  // row < 2^25, use reciprocal multiply: q = (v * recip) >> 32 then correct
  logic [24:0] v_c;
  logic [31:0] recip;
  logic [6:0]  hm1;
  assign hm1   = h_c - 7'd1;
  assign recip = recip_of(hm1);
  assign v_c   = pos_q[40] ? 25'd0 : pos_q[40:16];

  tag_t t3_q;
  logic [24:0] v3_q;
  logic [56:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t3_q   <= t2_q;
      v3_q   <= v_c;
      prod_q <= 57'(v_c) * 57'(recip);
    end
  end

  // stage C: remainder with up to two corrections
  logic [24:0] qq, rem0;
  logic [31:0] rm;
  always_comb begin
    qq   = prod_q[56:32];
    rem0 = v3_q - 25'(32'(qq) * 32'(hm1));
    rm   = 32'(rem0);
    if (rm >= 32'(hm1)) rm = rm - 32'(hm1);
    if (rm >= 32'(hm1)) rm = rm - 32'(hm1);
  end

  tag_t t4_q;
  logic [5:0] row4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t4_q   <= t3_q;
      row4_q <= rm[5:0];
    end
  end

  // stage D: texel address
  logic [12:0] addr_c;
  assign addr_c = 13'(row4_q) * 13'(w_c) + 13'(t4_q.col);

  tag_t t5_q;
  logic [12:0] addr5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t5_q    <= t4_q;
      addr5_q <= addr_c;
    end
  end

  // valid bits of the datapath stages past the divider
  logic v2, v3, v4, v5, v6;

  // store: load writes and samples read in item order at this stage
  logic [31:0] mem [Depth];
  logic [31:0] rd_q;
  logic        wr_en;
  logic        rd_ok;
  logic [AW-1:0] wa, ra;
  assign wa    = AW'({t5_q.tex, 12'd0} >> (12 - $clog2(TexSlot))) + AW'(t5_q.taddr);
  assign ra    = AW'(32'(t5_q.tex) * TexSlot + 32'(addr5_q));
  assign wr_en = adv && v5 && t5_q.vld && t5_q.load && t5_q.tex_ok
                 && (32'(t5_q.taddr) < TexSlot);
  assign rd_ok = t5_q.tex_ok && (32'(addr5_q) < TexSlot);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[AW'(32'(t5_q.tex) * TexSlot + 32'(t5_q.taddr))] <= t5_q.word;
    if (adv) rd_q <= mem[ra];
  end

  tag_t t6_q;
  logic ok6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t6_q  <= t5_q;
      ok6_q <= rd_ok;
    end
  end

  // divider tags hold no valid item until the divider has filled after reset
  logic [4:0] fill_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fill_q <= '0;
    else if (adv && fill_q != 5'd24) fill_q <= fill_q + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {vld2_q, v3, v4, v5, v6} <= '0;
    end else if (adv) begin
      vld2_q <= t1.vld && (fill_q >= 5'd23);
      v3     <= vld2_q;
      v4     <= v3;
      v5     <= v4;
      v6     <= v5;
    end
  end
  assign v2 = vld2_q;

  // output register
  twcp_pkg::out_item_t o_q;
  logic emit;
  assign emit = v6 && t6_q.vld && !t6_q.load;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= emit;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_q.out_x <= t6_q.px;
      o_q.out_y <= t6_q.py;
      case (t6_q.kind)
        KColor:  begin o_q.out_color <= t6_q.color; o_q.out_write <= 1'b1; end
        KTex:    begin o_q.out_color <= ok6_q ? rd_q : 32'd0; o_q.out_write <= 1'b1; end
        default: begin o_q.out_color <= 32'd0; o_q.out_write <= 1'b0; end
      endcase
    end
  end
  assign out_valid_o = out_v_q;
  assign out_item_o  = o_q;

  logic unused_c;
  assign unused_c = ^{wa, v2};

  // checks
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("stalled with empty output");
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> in_ready_o)
    else $error("store write during stall");
endmodule

// File: design/twcp_step_div.sv
// Pipelined restoring divider: step = (h << 16) / wall_height, one bit a stage
module twcp_step_div #(
  parameter int unsigned Tag = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [22:0]     num_i,
  input  logic [15:0]     den_i,
  input  logic [Tag-1:0]  tag_i,
  output logic [22:0]     quo_o,
  output logic [Tag-1:0]  tag_o
);
  localparam int unsigned N = 23;

  logic [N-1:0]   q_q [1:N];
  logic [16:0]    r_q [1:N];
  logic [15:0]    d_q [1:N];
  logic [Tag-1:0] t_q [1:N];

  // one quotient bit per stage, stages advance together with the pipeline
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [N-1:0]   q_s;
    logic [16:0]    r_s;
    logic [15:0]    d_s;
    logic [Tag-1:0] t_s;
    logic [17:0]    rs;
    logic [17:0]    diff;
    // the ports feed the first stage
    if (s == 0) begin : g_first
      assign q_s = num_i;
      assign r_s = '0;
      assign d_s = den_i;
      assign t_s = tag_i;
    end else begin : g_next
      assign q_s = q_q[s];
      assign r_s = r_q[s];
      assign d_s = d_q[s];
      assign t_s = t_q[s];
    end
    assign rs   = {r_s, q_s[N-1]};
    assign diff = rs - {2'b00, d_s};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!diff[17]) begin
          r_q[s+1] <= diff[16:0];
          q_q[s+1] <= {q_s[N-2:0], 1'b1};
        end else begin
          r_q[s+1] <= rs[16:0];
          q_q[s+1] <= {q_s[N-2:0], 1'b0};
        end
        d_q[s+1] <= d_s;
        t_q[s+1] <= t_s;
      end
    end
  end

  assign quo_o = q_q[N];
  assign tag_o = t_q[N];

  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule

// File: verif/testbench.sv
// Testbench for the textured wall column pixel core: random texel loads and pixel items
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TexDim  = twcp_pkg::MaxTexDimDef;
  localparam int unsigned NumTex  = twcp_pkg::NumTexturesDef;
  localparam int unsigned ScrH    = twcp_pkg::ScreenHeightDef;
  localparam int unsigned TexSlot = TexDim * TexDim;
  localparam int unsigned Latency = 28;

  // scoreboard: mirrors texel store and registers, holds expected pixels
  class pixel_scoreboard;
    logic [31:0] texels [NumTex*TexSlot];
    bit          loaded [NumTex*TexSlot];
    logic [6:0]  tex_w, tex_h;
    logic [31:0] ceil_col, floor_col;
    twcp_pkg::out_item_t pending[$];
    int          errors;
    int          pixels_checked;

    function void reset_regs();
      tex_w = 7'd64;
      tex_h = 7'd64;
      ceil_col = twcp_pkg::CeilingReset;
      floor_col = twcp_pkg::FloorReset;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        twcp_pkg::RegTexWidth:  tex_w = data[6:0];
        twcp_pkg::RegTexHeight: tex_h = data[6:0];
        twcp_pkg::RegCeiling:   ceil_col = data;
        twcp_pkg::RegFloor:     floor_col = data;
        default: ;
      endcase
    endfunction

    // texel address for an inside-span pixel; -1 when outside the texture
    function int sample_addr(twcp_pkg::in_item_t it);
      int unsigned h, w, lh, row;
      longint unsigned stp;
      longint pos, base;
      h = (tex_h < 2) ? 2 : (tex_h > TexDim ? TexDim : tex_h);
      w = (tex_w < 1) ? 1 : (tex_w > TexDim ? TexDim : tex_w);
      lh = (it.wall_height == 0) ? 1 : it.wall_height;
      stp = (longint'(h) << 16) / lh;
      base = longint'(it.pixel_y) - ScrH / 2 + lh / 2;
      pos = base * longint'(stp);
      row = (pos < 0) ? 0 : int'((longint'(pos) >>> 16) % (h - 1));
      if (row * w + it.tex_column >= TexSlot) return -1;
      return int'(it.tex_select) * TexSlot + row * w + it.tex_column;
    endfunction

    function void note_input(twcp_pkg::in_item_t it);
      twcp_pkg::out_item_t r;
      int a;
      if (it.mode == twcp_pkg::ModeLoad) begin
        if (it.texel_addr < TexSlot) begin
          texels[it.tex_select*TexSlot + it.texel_addr] = it.texel_word;
          loaded[it.tex_select*TexSlot + it.texel_addr] = 1'b1;
        end
        return;
      end
      r.out_x = it.pixel_x;
      r.out_y = it.pixel_y;
      r.out_color = '0;
      r.out_write = 1'b1;
      if (it.pixel_y >= ScrH) r.out_write = 1'b0;
      else if (it.pixel_y >= it.span_bottom) r.out_color = floor_col;
      else if (it.pixel_y < it.span_top) r.out_color = ceil_col;
      else if (it.pixel_y == it.span_top) r.out_write = 1'b0;
      else begin
        a = sample_addr(it);
        r.out_color = (a < 0) ? 32'd0 : texels[a];
      end
      pending.push_back(r);
    endfunction

    function void check_result(twcp_pkg::out_item_t got);
      twcp_pkg::out_item_t exp_r;
      pixels_checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.out_x !== exp_r.out_x || got.out_y !== exp_r.out_y ||
          got.out_color !== exp_r.out_color || got.out_write !== exp_r.out_write) begin
        $display("%0t: pixel mismatch exp x=%0d y=%0d c=%h w=%b got x=%0d y=%0d c=%h w=%b",
                 $realtime, exp_r.out_x, exp_r.out_y, exp_r.out_color, exp_r.out_write,
                 got.out_x, got.out_y, got.out_color, got.out_write);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  twcp_pkg::in_item_t  in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  twcp_pkg::out_item_t out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = twcp_pkg::RegTexWidth;
  logic [31:0] cfg_data_i = '0;

  pixel_scoreboard sb;
  bit stall_on;
  int loads_sent, pixels_sent;

  textured_wall_column_pixel_core u_top (.*);

  always #10 clk_i = ~clk_i;

  // receiver stalls on a rotating pattern, switched off in quiet phases
  int unsigned stall_cnt;
  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    out_ready_i <= !stall_on || (stall_cnt % 11 < 6) || ($urandom_range(3) == 0);
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);

  // send one item, holding valid until accepted
  task automatic send_item(twcp_pkg::in_item_t it);
    @(negedge clk_i);
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
    if (it.mode == twcp_pkg::ModeLoad) loads_sent++;
    else pixels_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic load_texel(int tex, int addr, logic [31:0] word);
    twcp_pkg::in_item_t it;
    it = '0;
    it.mode = twcp_pkg::ModeLoad;
    it.tex_select = 2'(tex);
    it.texel_addr = 12'(addr);
    it.texel_word = word;
    send_item(it);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    idle_input();
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // pixel that samples only loaded texels where it falls inside the span;
  // the column is moved onto the loaded texel of its 64-texel line if needed
  function automatic twcp_pkg::in_item_t make_pixel(int y, int y1, int y2, int lh, int col);
    twcp_pkg::in_item_t it;
    int a;
    it = '0;
    it.mode = twcp_pkg::ModePixel;
    it.tex_select = 2'($urandom_range(3));
    it.texel_addr = 12'($urandom);
    it.texel_word = $urandom;
    it.pixel_x = 10'($urandom);
    it.pixel_y = 10'(y);
    it.span_top = 10'(y1);
    it.span_bottom = 11'(y2);
    it.wall_height = 16'(lh);
    it.tex_column = 6'(col);
    if (y < ScrH && y < y2 && y > y1) begin
      a = sb.sample_addr(it);
      if (a >= 0 && !sb.loaded[a])
        it.tex_column = 6'((TexDim - ((a - int'(it.tex_column)) % TexDim)) % TexDim);
      a = sb.sample_addr(it);
      if (a >= 0 && !sb.loaded[a]) it.pixel_y = 10'(y1);
    end
    return it;
  endfunction

  // load one texel at the start of every 64-texel line of each texture
  task automatic fill_all_textures();
    for (int t = 0; t < NumTex; t++)
      for (int a = 0; a < TexSlot; a += TexDim) load_texel(t, a, $urandom);
  endtask

  task automatic random_phase(int count);
    twcp_pkg::in_item_t it;
    int burst, y1, y2;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        if (stall_on) begin
          idle_input();
          repeat ($urandom_range(4)) @(negedge clk_i);
        end
        burst = $urandom_range(1, 20);
      end
      burst--;
      y1 = $urandom_range(1023);
      y2 = $urandom_range(1024);
      if ($urandom_range(9) < 7) begin
        y1 = $urandom_range(ScrH - 1);
        y2 = $urandom_range(y1, 1024);
      end
      if ($urandom_range(9) == 0) begin
        it = '0;
        it.mode = twcp_pkg::ModeLoad;
        it.tex_select = 2'($urandom);
        it.texel_addr = 12'($urandom);
        it.texel_word = $urandom;
        it.pixel_x = 10'($urandom); it.pixel_y = 10'($urandom);
        it.span_top = 10'($urandom); it.span_bottom = 11'($urandom);
        it.wall_height = 16'($urandom); it.tex_column = 6'($urandom);
        send_item(it);
      end else begin
        it = make_pixel($urandom_range(9) < 8 ? $urandom_range(y1, y2 + 3) % 1024
                                              : $urandom_range(1023),
                        y1, y2,
                        $urandom_range(3) == 0 ? $urandom_range(65535)
                                               : $urandom_range(0, 1200),
                        $urandom_range(63));
        send_item(it);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    stall_on = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    fill_all_textures();

    // directed: each region, zero height, off-screen row, field extremes
    send_item(make_pixel(10, 100, 300, 200, 5));
    send_item(make_pixel(100, 100, 300, 200, 5));
    send_item(make_pixel(150, 100, 300, 200, 63));
    send_item(make_pixel(300, 100, 300, 200, 5));
    send_item(make_pixel(511, 0, 1024, 0, 0));
    send_item(make_pixel(1023, 0, 1024, 65535, 63));
    send_item(make_pixel(512, 0, 1024, 1, 0));
    send_item(make_pixel(1, 0, 1024, 65535, 63));
    send_item(make_pixel(0, 0, 0, 1, 0));
    send_item(make_pixel(200, 1023, 1024, 3, 7));
    load_texel(3, 4095, 32'hFFFF_FFFF);
    load_texel(0, 0, 32'h0);
    send_item(make_pixel(257, 256, 600, 1, 63));
    drain();

    // settings sweep including the extremes; width over 64 clamps, height 0 clamps
    stall_on = 1'b1;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_cfg(twcp_pkg::RegTexWidth, 32'd1);
          write_cfg(twcp_pkg::RegTexHeight, 32'd2);
        end
        1: begin
          write_cfg(twcp_pkg::RegTexWidth, 32'd64);
          write_cfg(twcp_pkg::RegTexHeight, 32'd64);
        end
        2: begin
          write_cfg(twcp_pkg::RegTexWidth, 32'd127);
          write_cfg(twcp_pkg::RegTexHeight, 32'd0);
        end
        3: begin
          write_cfg(twcp_pkg::RegTexWidth, 32'd13);
          write_cfg(twcp_pkg::RegTexHeight, 32'd37);
        end
        4: begin
          write_cfg(twcp_pkg::RegTexWidth, 32'd0);
          write_cfg(twcp_pkg::RegTexHeight, 32'd127);
        end
        default: begin
          write_cfg(twcp_pkg::RegTexWidth, $urandom_range(1, 64));
          write_cfg(twcp_pkg::RegTexHeight, $urandom_range(2, 64));
        end
      endcase
      write_cfg(twcp_pkg::RegCeiling,
                p == 0 ? 32'h0 : (p == 1 ? 32'hFFFF_FFFF : $urandom));
      write_cfg(twcp_pkg::RegFloor,
                p == 0 ? 32'hFFFF_FFFF : (p == 1 ? 32'h0 : $urandom));
      stall_on = (p != 3);
      random_phase(165);
      drain();
    end

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d pixels never arrived", $realtime, sb.pending.size());
      sb.errors++;
    end
    $display("Covered %0d texel loads and %0d pixel items, %0d pixels checked,",
             loads_sent, pixels_sent, sb.pixels_checked);
    $display("over six register settings with burst input and stalled output.");
    if (sb.errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
